// File: src/four_level_priority_job_queue_core_assert.svh
// Assertion macros shared by the job queue modules.
// Each macro expands to one labelled concurrent assertion on the rising clock edge.
// The assertion is switched off while reset is high.
`ifndef FOUR_LEVEL_PRIORITY_JOB_QUEUE_CORE_ASSERT_SVH
`define FOUR_LEVEL_PRIORITY_JOB_QUEUE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FLJQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FLJQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/fljq_pkg.sv
// ----------------------------------------------------------------------------
// fljq_pkg
// Shared constants, types and pointer helpers for the priority job queue.
// ----------------------------------------------------------------------------
package fljq_pkg;

  // Queue geometry.
  localparam int DEPTH       = 16;
  localparam int LEVELS      = 4;
  localparam int PTR_W       = $clog2(DEPTH);
  localparam int CNT_W       = PTR_W + 1;
  localparam int LVL_W       = $clog2(LEVELS);
  localparam int ADDR_W      = LVL_W + PTR_W;
  localparam int STORE_WORDS = LEVELS << PTR_W;

  // Field widths of the transactions.
  localparam int CMD_W    = 2;
  localparam int LEVEL_W  = 2;
  localparam int ID_W     = 16;
  localparam int PAGES_W  = 16;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 3;
  localparam int JOB_W    = ID_W + PAGES_W;
  localparam int SUM_W    = ((PTR_W > POS_W) ? PTR_W : POS_W) + 1;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [LVL_W-1:0] lvl_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ    = 2'd0,
    CMD_DEQ    = 2'd1,
    CMD_CANCEL = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_DENIED = 3'd3,
    ST_RANGE  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DEQ_READ,
    S_SH_RD,
    S_SH_WR,
    S_RESULT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    latch_in;
    logic    status_load;
    status_t status_code;
    logic    enq_write;
    logic    deq_take;
    logic    can_start;
    logic    clr_ptrs;
    logic    rd_shift;
    logic    wr_shift;
    logic    load_data;
    logic    out_load;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_t cmd;
    logic privileged;
    logic level_ok;
    logic full;
    logic empty;
    logic any_ne;
    logic pos_ok;
    logic rem_start_zero;
    logic rem_last;
    logic out_free;
  } dp_stat_t;

  // Circular increment of a slot index.
  function automatic ptr_t next_ptr(ptr_t p);
    return (p == ptr_t'(DEPTH - 1)) ? '0 : p + ptr_t'(1);
  endfunction

  // Circular decrement of a slot index.
  function automatic ptr_t prev_ptr(ptr_t p);
    return (p == '0) ? ptr_t'(DEPTH - 1) : p - ptr_t'(1);
  endfunction

  // Number of jobs held between a head and a tail pointer.
  function automatic ptr_t ptr_count(ptr_t head, ptr_t tail);
    logic [CNT_W-1:0] diff;
    if (tail >= head) begin
      diff = {1'b0, tail} - {1'b0, head};
    end else begin
      diff = {1'b0, tail} + CNT_W'(DEPTH) - {1'b0, head};
    end
    return diff[PTR_W-1:0];
  endfunction

endpackage

// File: src/fljq_ram.sv
// ----------------------------------------------------------------------------
// fljq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fljq_ram #(
  parameter int DATA_W = 32,
  parameter int WORDS  = 64,
  parameter int ADR_W  = $clog2(WORDS)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADR_W-1:0]  waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADR_W-1:0]  raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [WORDS];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/fljq_datapath.sv
// ----------------------------------------------------------------------------
// fljq_datapath
// Pointers, job store, request latch, result staging and output register.
// ----------------------------------------------------------------------------
`include "four_level_priority_job_queue_core_assert.svh"

module fljq_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  fljq_pkg::ctl_cmd_t             ctl,
  output fljq_pkg::dp_stat_t             stat,
  input  logic [fljq_pkg::CMD_W-1:0]     cmd,
  input  logic [fljq_pkg::LEVEL_W-1:0]   level,
  input  logic [fljq_pkg::ID_W-1:0]      job_id,
  input  logic [fljq_pkg::PAGES_W-1:0]   page_count,
  input  logic [fljq_pkg::POS_W-1:0]     position,
  input  logic                           privileged,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic [fljq_pkg::STATUS_W-1:0]  status,
  output logic [fljq_pkg::ID_W-1:0]      out_job_id,
  output logic [fljq_pkg::PAGES_W-1:0]   out_page_count,
  output logic [fljq_pkg::LEVEL_W-1:0]   out_level,
  output logic                           emergency_pending
);

  // Latched request.
  fljq_pkg::cmd_t                q_cmd;
  logic [fljq_pkg::LEVEL_W-1:0]  q_level;
  logic [fljq_pkg::ID_W-1:0]     q_id;
  logic [fljq_pkg::PAGES_W-1:0]  q_pages;
  logic [fljq_pkg::POS_W-1:0]    q_pos;
  logic                          q_priv;

  // Queue pointers.
  fljq_pkg::ptr_t head [fljq_pkg::LEVELS];
  fljq_pkg::ptr_t tail [fljq_pkg::LEVELS];

  // Cancel shift state.
  fljq_pkg::ptr_t cur;
  fljq_pkg::ptr_t rem;

  // Result staging.
  fljq_pkg::status_t             res_status;
  logic [fljq_pkg::ID_W-1:0]     res_id;
  logic [fljq_pkg::PAGES_W-1:0]  res_pages;
  logic [fljq_pkg::LEVEL_W-1:0]  res_level;

  // Combinational helpers.
  fljq_pkg::lvl_t               lidx;
  fljq_pkg::lvl_t               sel_lvl;
  logic                         any_ne;
  logic                         level_ok;
  fljq_pkg::ptr_t               count;
  fljq_pkg::ptr_t               start_cur;
  fljq_pkg::ptr_t               rem_start;
  logic [fljq_pkg::SUM_W-1:0]   sum;
  logic                         out_free;

  // Store ports.
  logic                           ram_we;
  logic [fljq_pkg::ADDR_W-1:0]    ram_waddr;
  logic [fljq_pkg::JOB_W-1:0]     ram_wdata;
  logic [fljq_pkg::ADDR_W-1:0]    ram_raddr;
  logic [fljq_pkg::JOB_W-1:0]     ram_rdata;

  // Latch the request when the controller accepts it.
  always_ff @(posedge clk) begin
    if (ctl.latch_in) begin
      q_cmd   <= fljq_pkg::cmd_t'(cmd);
      q_level <= level;
      q_id    <= job_id;
      q_pages <= page_count;
      q_pos   <= position;
      q_priv  <= privileged;
    end
  end

  // Level decode and per-level occupancy.
  always_comb begin
    lidx     = fljq_pkg::LVL_W'(q_level);
    level_ok = 32'(q_level) < 32'(fljq_pkg::LEVELS);
    count    = fljq_pkg::ptr_count(head[lidx], tail[lidx]);
  end

  // Highest non-empty level for dequeue; a later level overrides an earlier one.
  always_comb begin
    any_ne  = 1'b0;
    sel_lvl = '0;
    for (int l = 0; l < fljq_pkg::LEVELS; l++) begin
      if (head[l] != tail[l]) begin
        any_ne  = 1'b1;
        sel_lvl = fljq_pkg::LVL_W'(l);
      end
    end
  end

  // Start slot and number of moves for a cancel.
  always_comb begin
    sum = fljq_pkg::SUM_W'(head[lidx]) + fljq_pkg::SUM_W'(q_pos) - fljq_pkg::SUM_W'(1);
    if (sum >= fljq_pkg::SUM_W'(fljq_pkg::DEPTH)) begin
      sum = sum - fljq_pkg::SUM_W'(fljq_pkg::DEPTH);
    end
    start_cur = sum[fljq_pkg::PTR_W-1:0];
    rem_start = count - fljq_pkg::PTR_W'(q_pos);
  end

  assign out_free = !out_valid || !out_stall;

  // Status towards the controller.
  always_comb begin
    stat.cmd            = q_cmd;
    stat.privileged     = q_priv;
    stat.level_ok       = level_ok;
    stat.full           = fljq_pkg::next_ptr(tail[lidx]) == head[lidx];
    stat.empty          = head[lidx] == tail[lidx];
    stat.any_ne         = any_ne;
    stat.pos_ok         = (q_pos != '0) && (32'(q_pos) <= 32'(count));
    stat.rem_start_zero = 32'(q_pos) == 32'(count);
    stat.rem_last       = rem == fljq_pkg::ptr_t'(1);
    stat.out_free       = out_free;
  end

  // Head and tail pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < fljq_pkg::LEVELS; l++) begin
        head[l] <= '0;
        tail[l] <= '0;
      end
    end else if (ctl.clr_ptrs) begin
      for (int l = 0; l < fljq_pkg::LEVELS; l++) begin
        head[l] <= '0;
        tail[l] <= '0;
      end
    end else begin
      if (ctl.enq_write) begin
        tail[lidx] <= fljq_pkg::next_ptr(tail[lidx]);
      end
      if (ctl.can_start) begin
        tail[lidx] <= fljq_pkg::prev_ptr(tail[lidx]);
      end
      if (ctl.deq_take) begin
        head[sel_lvl] <= fljq_pkg::next_ptr(head[sel_lvl]);
      end
    end
  end

  // Cancel walk: slot being filled and moves still to do.
  always_ff @(posedge clk) begin
    if (ctl.can_start) begin
      cur <= start_cur;
      rem <= rem_start;
    end else if (ctl.wr_shift) begin
      cur <= fljq_pkg::next_ptr(cur);
      rem <= rem - fljq_pkg::ptr_t'(1);
    end
  end

  // Store addressing: the read port serves dequeue and the cancel walk.
  always_comb begin
    ram_we    = ctl.enq_write || ctl.wr_shift;
    ram_waddr = ctl.wr_shift ? {lidx, cur} : {lidx, tail[lidx]};
    ram_wdata = ctl.wr_shift ? ram_rdata : {q_id, q_pages};
    ram_raddr = ctl.rd_shift ? {lidx, fljq_pkg::next_ptr(cur)} : {sel_lvl, head[sel_lvl]};
  end

  fljq_ram #(
    .DATA_W (fljq_pkg::JOB_W),
    .WORDS  (fljq_pkg::STORE_WORDS),
    .ADR_W  (fljq_pkg::ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result staging: status and level first, then job data for a dequeue.
  always_ff @(posedge clk) begin
    if (ctl.status_load) begin
      res_status <= ctl.status_code;
      res_id     <= '0;
      res_pages  <= '0;
      res_level  <= ctl.deq_take ? fljq_pkg::LEVEL_W'(sel_lvl) : '0;
    end
    if (ctl.load_data) begin
      res_id    <= ram_rdata[fljq_pkg::JOB_W-1:fljq_pkg::PAGES_W];
      res_pages <= ram_rdata[fljq_pkg::PAGES_W-1:0];
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      status            <= res_status;
      out_job_id        <= res_id;
      out_page_count    <= res_pages;
      out_level         <= res_level;
      emergency_pending <= head[fljq_pkg::LEVELS-1] != tail[fljq_pkg::LEVELS-1];
    end
  end

  // An accepted enqueue leaves its level non-empty.
  `FLJQ_ASSERT_NEXT(a_enq_not_empty, clk, rst, ctl.enq_write, head[lidx] != tail[lidx], "enqueue left level empty")
  // The cancel walk never moves a slot when no moves remain.
  `FLJQ_ASSERT_SAME(a_shift_rem, clk, rst, ctl.wr_shift, rem != '0, "shift with no moves left")
  // A cancel only starts on a position inside the level.
  `FLJQ_ASSERT_SAME(a_cancel_pos, clk, rst, ctl.can_start, level_ok && stat.pos_ok, "cancel out of range")

endmodule

// File: src/fljq_ctrl.sv
// ----------------------------------------------------------------------------
// fljq_ctrl
// Controller state machine: sequences each transaction through the datapath.
// ----------------------------------------------------------------------------
`include "four_level_priority_job_queue_core_assert.svh"

module fljq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  fljq_pkg::dp_stat_t  stat,
  output fljq_pkg::ctl_cmd_t  ctl
);

  fljq_pkg::state_t state;
  fljq_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fljq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = rst || (state != fljq_pkg::S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next      = state;
    ctl             = '0;
    ctl.status_code = fljq_pkg::ST_OK;
    unique case (state)
      fljq_pkg::S_IDLE: begin
        if (in_valid) begin
          ctl.latch_in = 1'b1;
          state_next   = fljq_pkg::S_DECODE;
        end
      end
      fljq_pkg::S_DECODE: begin
        ctl.status_load = 1'b1;
        state_next      = fljq_pkg::S_RESULT;
        unique case (stat.cmd)
          fljq_pkg::CMD_ENQ: begin
            if (!stat.level_ok || stat.full) begin
              ctl.status_code = fljq_pkg::ST_FULL;
            end else begin
              ctl.enq_write = 1'b1;
            end
          end
          fljq_pkg::CMD_DEQ: begin
            if (stat.any_ne) begin
              ctl.deq_take = 1'b1;
              state_next   = fljq_pkg::S_DEQ_READ;
            end else begin
              ctl.status_code = fljq_pkg::ST_EMPTY;
            end
          end
          fljq_pkg::CMD_CANCEL: begin
            priority if (!stat.privileged) begin
              ctl.status_code = fljq_pkg::ST_DENIED;
            end else if (!stat.level_ok || stat.empty) begin
              ctl.status_code = fljq_pkg::ST_EMPTY;
            end else if (!stat.pos_ok) begin
              ctl.status_code = fljq_pkg::ST_RANGE;
            end else begin
              ctl.can_start = 1'b1;
              if (!stat.rem_start_zero) begin
                state_next = fljq_pkg::S_SH_RD;
              end
            end
          end
          fljq_pkg::CMD_CLEAR: begin
            ctl.clr_ptrs = 1'b1;
          end
          default: begin
            ctl.status_code = fljq_pkg::ST_OK;
          end
        endcase
      end
      fljq_pkg::S_DEQ_READ: begin
        ctl.load_data = 1'b1;
        state_next    = fljq_pkg::S_RESULT;
      end
      fljq_pkg::S_SH_RD: begin
        ctl.rd_shift = 1'b1;
        state_next   = fljq_pkg::S_SH_WR;
      end
      fljq_pkg::S_SH_WR: begin
        ctl.wr_shift = 1'b1;
        state_next   = stat.rem_last ? fljq_pkg::S_RESULT : fljq_pkg::S_SH_RD;
      end
      fljq_pkg::S_RESULT: begin
        if (stat.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = fljq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = fljq_pkg::S_IDLE;
      end
    endcase
  end

  // An accepted transaction is decoded in the following cycle.
  `FLJQ_ASSERT_NEXT(a_acc_decode, clk, rst, in_valid && !in_stall, state == fljq_pkg::S_DECODE, "accept not followed by decode")
  // The output register is only loaded when it can take the result.
  `FLJQ_ASSERT_SAME(a_load_free, clk, rst, ctl.out_load, stat.out_free, "result overwrote pending output")
  // A result load always returns the controller to idle.
  `FLJQ_ASSERT_NEXT(a_load_idle, clk, rst, ctl.out_load, state == fljq_pkg::S_IDLE, "no return to idle after result")

endmodule

// File: src/four_level_priority_job_queue_core.sv
// Enqueue, clear and rejected commands: accept, decode, then the result state, which waits
// for a free output register; a dequeue adds a store read. A cancel makes m moves, m being
// the jobs behind the removed one (at most DEPTH-2), each a read then a write on the
// single-read-port job store. One transaction at a time: the next is accepted the cycle
// after the result is registered. Reset clears all head and tail pointers and the output
// valid flag; the job store is not cleared, and no slot is read before it is written.
// ----------------------------------------------------------------------------
// four_level_priority_job_queue_core
// Strict-priority job queue with four levels, cancel by position and clear.
// ----------------------------------------------------------------------------
module four_level_priority_job_queue_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [fljq_pkg::CMD_W-1:0]     cmd,
  input  logic [fljq_pkg::LEVEL_W-1:0]   level,
  input  logic [fljq_pkg::ID_W-1:0]      job_id,
  input  logic [fljq_pkg::PAGES_W-1:0]   page_count,
  input  logic [fljq_pkg::POS_W-1:0]     position,
  input  logic                           privileged,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [fljq_pkg::STATUS_W-1:0]  status,
  output logic [fljq_pkg::ID_W-1:0]      out_job_id,
  output logic [fljq_pkg::PAGES_W-1:0]   out_page_count,
  output logic [fljq_pkg::LEVEL_W-1:0]   out_level,
  output logic                           emergency_pending
);

  fljq_pkg::ctl_cmd_t ctl;
  fljq_pkg::dp_stat_t stat;

  // Controller.
  fljq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  // Datapath.
  fljq_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .ctl               (ctl),
    .stat              (stat),
    .cmd               (cmd),
    .level             (level),
    .job_id            (job_id),
    .page_count        (page_count),
    .position          (position),
    .privileged        (privileged),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .status            (status),
    .out_job_id        (out_job_id),
    .out_page_count    (out_page_count),
    .out_level         (out_level),
    .emergency_pending (emergency_pending)
  );

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the four-level priority job queue core. A behavioural
// model of the four circular job queues predicts every result transaction; the
// checker compares each one field by field while both channels idle at random.
// ----------------------------------------------------------------------------
module tb;

  // Cycles without any transaction before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 3000;
  // Length of the long receiver hold-off used to fill the block.
  localparam int HOLD_CYCLES    = 300;
  // Quiet cycles allowed after the last expected result.
  localparam int TAIL_CYCLES    = 40;

  typedef struct packed {
    fljq_pkg::status_t                status;
    logic [fljq_pkg::ID_W-1:0]        job_id;
    logic [fljq_pkg::PAGES_W-1:0]     page_count;
    logic [fljq_pkg::LEVEL_W-1:0]     level;
    logic                             emergency;
  } job_result_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [fljq_pkg::CMD_W-1:0]       cmd = '0;
  logic [fljq_pkg::LEVEL_W-1:0]     level = '0;
  logic [fljq_pkg::ID_W-1:0]        job_id = '0;
  logic [fljq_pkg::PAGES_W-1:0]     page_count = '0;
  logic [fljq_pkg::POS_W-1:0]       position = '0;
  logic                             privileged = 1'b0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [fljq_pkg::STATUS_W-1:0]    status;
  logic [fljq_pkg::ID_W-1:0]        out_job_id;
  logic [fljq_pkg::PAGES_W-1:0]     out_page_count;
  logic [fljq_pkg::LEVEL_W-1:0]     out_level;
  logic                             emergency_pending;

  // Model state: one circular queue of packed jobs per level.
  logic [fljq_pkg::JOB_W-1:0]       job_mem [fljq_pkg::LEVELS][fljq_pkg::DEPTH];
  int                               head_idx [fljq_pkg::LEVELS];
  int                               tail_idx [fljq_pkg::LEVELS];

  job_result_t          pending_results [$];
  int                   errors = 0;
  int                   burst_left = 0;
  int                   hold_requests = 0;
  int                   hold_served = 0;
  int                   hold_left = 0;
  int                   stall_mode = 0;
  int                   phase_left = 0;
  int                   idle_cycles = 0;

  four_level_priority_job_queue_core u_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .cmd               (cmd),
    .level             (level),
    .job_id            (job_id),
    .page_count        (page_count),
    .position          (position),
    .privileged        (privileged),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .status            (status),
    .out_job_id        (out_job_id),
    .out_page_count    (out_page_count),
    .out_level         (out_level),
    .emergency_pending (emergency_pending)
  );

  // Free-running clock, 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Number of jobs currently held by one level of the model.
  function automatic int level_jobs(int lv);
    return (tail_idx[lv] + fljq_pkg::DEPTH - head_idx[lv]) % fljq_pkg::DEPTH;
  endfunction

  // Applies one command to the model and returns the result it should produce.
  function automatic job_result_t apply_to_model(fljq_pkg::cmd_t c,
                                                 logic [fljq_pkg::LEVEL_W-1:0] lv,
                                                 logic [fljq_pkg::ID_W-1:0] id,
                                                 logic [fljq_pkg::PAGES_W-1:0] pages,
                                                 logic [fljq_pkg::POS_W-1:0] pos,
                                                 logic priv);
    job_result_t r;
    int l;
    int p;
    int cnt;
    int cur;
    int nx;
    int k;
    bit found;
    r = '0;
    r.status = fljq_pkg::ST_OK;
    l = int'(lv);
    p = int'(pos);
    found = 1'b0;
    case (c)
      fljq_pkg::CMD_ENQ: begin
        if (l >= fljq_pkg::LEVELS ||
            (tail_idx[l] + 1) % fljq_pkg::DEPTH == head_idx[l]) begin
          r.status = fljq_pkg::ST_FULL;
        end else begin
          job_mem[l][tail_idx[l]] = {id, pages};
          tail_idx[l] = (tail_idx[l] + 1) % fljq_pkg::DEPTH;
        end
      end
      fljq_pkg::CMD_DEQ: begin
        // Strict priority: the highest non-empty level is served.
        r.status = fljq_pkg::ST_EMPTY;
        for (k = fljq_pkg::LEVELS - 1; k >= 0; k--) begin
          if (!found && head_idx[k] != tail_idx[k]) begin
            r.job_id     = job_mem[k][head_idx[k]][fljq_pkg::JOB_W-1:fljq_pkg::PAGES_W];
            r.page_count = job_mem[k][head_idx[k]][fljq_pkg::PAGES_W-1:0];
            r.level      = fljq_pkg::LEVEL_W'(k);
            r.status     = fljq_pkg::ST_OK;
            head_idx[k]  = (head_idx[k] + 1) % fljq_pkg::DEPTH;
            found        = 1'b1;
          end
        end
      end
      fljq_pkg::CMD_CANCEL: begin
        // Permission is checked first, then emptiness, then the position.
        if (!priv) begin
          r.status = fljq_pkg::ST_DENIED;
        end else if (l >= fljq_pkg::LEVELS || head_idx[l] == tail_idx[l]) begin
          r.status = fljq_pkg::ST_EMPTY;
        end else begin
          cnt = level_jobs(l);
          if (p < 1 || p > cnt) begin
            r.status = fljq_pkg::ST_RANGE;
          end else begin
            cur = (head_idx[l] + p - 1) % fljq_pkg::DEPTH;
            for (k = 0; k < cnt - p; k++) begin
              nx = (cur + 1) % fljq_pkg::DEPTH;
              job_mem[l][cur] = job_mem[l][nx];
              cur = nx;
            end
            tail_idx[l] = (tail_idx[l] + fljq_pkg::DEPTH - 1) % fljq_pkg::DEPTH;
          end
        end
      end
      default: begin
        for (k = 0; k < fljq_pkg::LEVELS; k++) begin
          head_idx[k] = 0;
          tail_idx[k] = 0;
        end
      end
    endcase
    r.emergency = (head_idx[fljq_pkg::LEVELS-1] != tail_idx[fljq_pkg::LEVELS-1]);
    return r;
  endfunction

  // Offers one input transaction, idling between bursts, and records its outcome.
  task automatic send_job(fljq_pkg::cmd_t c, logic [fljq_pkg::LEVEL_W-1:0] lv,
                          logic [fljq_pkg::ID_W-1:0] id,
                          logic [fljq_pkg::PAGES_W-1:0] pages,
                          logic [fljq_pkg::POS_W-1:0] pos, logic priv);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid   <= 1'b1;
    cmd        <= c;
    level      <= lv;
    job_id     <= id;
    page_count <= pages;
    position   <= pos;
    privileged <= priv;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(apply_to_model(c, lv, id, pages, pos, priv));
  endtask

  // Reports one field that differs from its prediction.
  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      errors++;
    end
  endtask

  // Commands on an empty queue: dequeue, cancel and a refused cancel.
  task automatic test_empty_queue();
    send_job(fljq_pkg::CMD_DEQ, 2'd0, 16'h0000, 16'h0000, 4'd0, 1'b0);
    send_job(fljq_pkg::CMD_CANCEL, 2'd3, 16'h1234, 16'h0001, 4'd1, 1'b1);
    send_job(fljq_pkg::CMD_CANCEL, 2'd2, 16'hffff, 16'hffff, 4'd15, 1'b0);
  endtask

  // Fills the batch level to capacity with extreme ids, then overflows it.
  task automatic test_fill_to_full();
    int i;
    for (i = 0; i < fljq_pkg::DEPTH; i++) begin
      if (i == 0) begin
        send_job(fljq_pkg::CMD_ENQ, 2'd0, 16'h0000, 16'h0000, 4'd0, 1'b0);
      end else if (i >= fljq_pkg::DEPTH - 2) begin
        send_job(fljq_pkg::CMD_ENQ, 2'd0, 16'hffff, 16'hffff, 4'd15, 1'b1);
      end else begin
        send_job(fljq_pkg::CMD_ENQ, 2'd0, 16'($urandom), 16'($urandom), 4'($urandom),
                 1'($urandom));
      end
    end
  endtask

  // Cancels on the full batch level: zero position, last job, first job, past the end.
  task automatic test_cancel_cases();
    send_job(fljq_pkg::CMD_CANCEL, 2'd0, 16'h0000, 16'h0000, 4'd0, 1'b1);
    send_job(fljq_pkg::CMD_CANCEL, 2'd0, 16'h0000, 16'h0000, 4'd15, 1'b1);
    send_job(fljq_pkg::CMD_CANCEL, 2'd0, 16'h0000, 16'h0000, 4'd1, 1'b1);
    send_job(fljq_pkg::CMD_CANCEL, 2'd0, 16'h0000, 16'h0000, 4'd14, 1'b1);
  endtask

  // Emergency flag, priority order across levels and clear of a busy queue.
  task automatic test_priority_and_clear();
    send_job(fljq_pkg::CMD_ENQ, 2'd1, 16'h00aa, 16'h5500, 4'd0, 1'b0);
    send_job(fljq_pkg::CMD_ENQ, 2'd3, 16'hbeef, 16'h0042, 4'd0, 1'b0);
    send_job(fljq_pkg::CMD_DEQ, 2'd0, 16'h0000, 16'h0000, 4'd0, 1'b0);
    send_job(fljq_pkg::CMD_DEQ, 2'd0, 16'h0000, 16'h0000, 4'd0, 1'b0);
    send_job(fljq_pkg::CMD_CLEAR, 2'd0, 16'h0000, 16'h0000, 4'd0, 1'b0);
  endtask

  // Mixed traffic in phases that fill, balance or drain the levels.
  task automatic test_random_traffic(int n_items);
    int i;
    int roll;
    int enq_pct;
    int deq_pct;
    int can_pct;
    int favourite;
    int n;
    logic [fljq_pkg::LEVEL_W-1:0] lv;
    logic [fljq_pkg::POS_W-1:0]   pos;
    logic                         priv;
    logic [fljq_pkg::ID_W-1:0]    id;
    logic [fljq_pkg::PAGES_W-1:0] pages;
    fljq_pkg::cmd_t               c;
    enq_pct = 40;
    deq_pct = 30;
    can_pct = 27;
    favourite = 0;
    for (i = 0; i < n_items; i++) begin
      // Pick a new traffic mix every few dozen transactions.
      if (i % 60 == 0) begin
        favourite = $urandom_range(0, fljq_pkg::LEVELS - 1);
        case ($urandom_range(0, 2))
          0: begin enq_pct = 40; deq_pct = 30; can_pct = 27; end
          1: begin enq_pct = 70; deq_pct = 10; can_pct = 18; end
          default: begin enq_pct = 20; deq_pct = 50; can_pct = 28; end
        endcase
      end
      lv    = $urandom_range(0, 1) ? fljq_pkg::LEVEL_W'(favourite)
                                   : fljq_pkg::LEVEL_W'($urandom_range(0, 3));
      id    = 16'($urandom);
      pages = 16'($urandom);
      pos   = 4'($urandom);
      priv  = 1'($urandom);
      if ($urandom_range(0, 19) == 0) begin
        id    = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        pages = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      end
      roll = $urandom_range(0, 99);
      if (roll < enq_pct) begin
        c = fljq_pkg::CMD_ENQ;
      end else if (roll < enq_pct + deq_pct) begin
        c = fljq_pkg::CMD_DEQ;
      end else if (roll < enq_pct + deq_pct + can_pct) begin
        // Mostly privileged cancels of a job that exists.
        c = fljq_pkg::CMD_CANCEL;
        priv = ($urandom_range(0, 9) != 0);
        n = level_jobs(int'(lv));
        if (n > 0 && $urandom_range(0, 4) != 0) begin
          pos = fljq_pkg::POS_W'($urandom_range(1, n));
        end
      end else begin
        c = fljq_pkg::CMD_CLEAR;
      end
      send_job(c, lv, id, pages, pos, priv);
    end
  endtask

  // Long receiver hold-off while the sender keeps offering back-to-back work.
  task automatic test_backpressure();
    int i;
    hold_requests++;
    burst_left = 20;
    for (i = 0; i < 20; i++) begin
      send_job(i % 3 == 2 ? fljq_pkg::CMD_DEQ : fljq_pkg::CMD_ENQ,
               fljq_pkg::LEVEL_W'($urandom_range(0, 3)),
               16'($urandom), 16'($urandom), 4'($urandom), 1'($urandom));
    end
  endtask

  // Receiver stall: a requested hold-off first, otherwise a random phase pattern.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      out_stall   <= 1'b1;
      hold_served <= hold_served + 1;
      hold_left   <= HOLD_CYCLES;
    end else begin
      if (phase_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        phase_left <= $urandom_range(20, 120);
      end else begin
        phase_left <= phase_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // Result checker: each accepted result transaction against the oldest prediction.
  always @(posedge clk) begin
    job_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: status 0x%0h job 0x%0h", status, out_job_id);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(status));
        check_field("out_job_id", 32'(want.job_id), 32'(out_job_id));
        check_field("out_page_count", 32'(want.page_count), 32'(out_page_count));
        check_field("out_level", 32'(want.level), 32'(out_level));
        check_field("emergency_pending", 32'(want.emergency), 32'(emergency_pending));
      end
    end
  end

  // Watchdog: ends the run if no transaction moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("four_level_priority_job_queue_core verification failed");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    for (int k = 0; k < fljq_pkg::LEVELS; k++) begin
      head_idx[k] = 0;
      tail_idx[k] = 0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_empty_queue();
    test_fill_to_full();
    test_cancel_cases();
    test_priority_and_clear();
    test_random_traffic(600);
    test_backpressure();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("four_level_priority_job_queue_core verification clean");
    end else begin
      $display("four_level_priority_job_queue_core verification failed");
    end
    $finish;
  end

endmodule
